@@ design/mca_pkg.sv @@
// Shared types and constants for the Moore cellular automaton step block.
// Used by mca_rule and moore_cellular_automaton_step; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mca_pkg;

  localparam int unsigned MAX_SIDE_DEF = 254;

  localparam int unsigned CFG_DW  = 8;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned COUNT_W = 4;

  localparam logic [CFG_DW-1:0]  GRID_SIDE_RST    = 8'd254;
  localparam logic [LIMIT_W-1:0] BIRTH_ABOVE_RST  = 4'd6;
  localparam logic [LIMIT_W-1:0] SURVIVE_LOW_RST  = 4'd5;
  localparam logic [LIMIT_W-1:0] SURVIVE_HIGH_RST = 4'd6;

  localparam logic [CFG_DW-1:0] GRID_SIDE_MIN = 8'd3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_GRID_SIDE    = 2'd0,
    CFG_BIRTH_ABOVE  = 2'd1,
    CFG_SURVIVE_LOW  = 2'd2,
    CFG_SURVIVE_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] birth_above;
    logic [LIMIT_W-1:0] survive_low;
    logic [LIMIT_W-1:0] survive_high;
  } rule_cfg_t;

endpackage

`default_nettype wire

@@ design/mca_rule.sv @@
// Birth and survival rule: counts the eight neighbors of a 3x3 window.
// Depends on mca_pkg for rule_cfg_t and widths.
`timescale 1ns / 1ps
`default_nettype none

module mca_rule
  import mca_pkg::*;
(
  input  wire logic [8:0] window,
  input  wire rule_cfg_t  rule_cfg,
  output logic            next_alive
);

  logic [COUNT_W-1:0] count;

  always_comb begin
    count = COUNT_W'(window[0]) + COUNT_W'(window[1]) + COUNT_W'(window[2])
          + COUNT_W'(window[3]) + COUNT_W'(window[5]) + COUNT_W'(window[6])
          + COUNT_W'(window[7]) + COUNT_W'(window[8]);
    if (window[4]) begin
      next_alive = (count >= rule_cfg.survive_low) && (count <= rule_cfg.survive_high);
    end else begin
      next_alive = (count > rule_cfg.birth_above);
    end
  end

endmodule

`default_nettype wire

@@ design/moore_cellular_automaton_step.sv @@
// Top level: one generation of a life-like automaton over a raster cell stream.
// Depends on mca_pkg and mca_rule.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_stall in_cell_alive         | cells in
//          | in_frame_first                          |
//  out     | out_valid out_stall out_next_alive      | results out
//          | out_frame_last                          |
//  cfg     | cfg_we cfg_index cfg_wdata              | register writes
//
// One cell per clock unless stalled; each result passes stage 1, then the output register.
// The rate is set by the single 2-bit line memory: one read and one write per cycle.
// After reset a clearing pass zeroes all MAX_SIDE+2 line memory entries; in_stall
// stays high during it. Each stage advances only when the stage after it is free.
`timescale 1ns / 1ps
`default_nettype none

module moore_cellular_automaton_step
  import mca_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cell_alive,
  input  wire logic              in_frame_first,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_next_alive,
  output logic                   out_frame_last,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned DEPTH = MAX_SIDE + 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (PW > CFG_DW) ? PW : CFG_DW;

  // configuration
  logic [CFG_DW-1:0] grid_side_r;
  rule_cfg_t         rule_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r             <= GRID_SIDE_RST;
      rule_cfg_r.birth_above  <= BIRTH_ABOVE_RST;
      rule_cfg_r.survive_low  <= SURVIVE_LOW_RST;
      rule_cfg_r.survive_high <= SURVIVE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_SIDE:    grid_side_r             <= cfg_wdata;
        CFG_BIRTH_ABOVE:  rule_cfg_r.birth_above  <= cfg_wdata[LIMIT_W-1:0];
        CFG_SURVIVE_LOW:  rule_cfg_r.survive_low  <= cfg_wdata[LIMIT_W-1:0];
        CFG_SURVIVE_HIGH: rule_cfg_r.survive_high <= cfg_wdata[LIMIT_W-1:0];
        default:          grid_side_r             <= grid_side_r;
      endcase
    end
  end

  // padded side, saturated
  logic [CW-1:0] side_sat;
  logic [CW-1:0] side_wide;
  logic [PW-1:0] side_pad;

  always_comb begin
    side_wide = CW'(grid_side_r);
    if (side_wide < CW'(GRID_SIDE_MIN)) begin
      side_sat = CW'(GRID_SIDE_MIN);
    end else if (side_wide > CW'(MAX_SIDE)) begin
      side_sat = CW'(MAX_SIDE);
    end else begin
      side_sat = side_wide;
    end
    side_pad = PW'(side_sat + CW'(2));
  end

  // stage 0: position tracking and memory read
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] col_r, col_nxt;
  logic [AW-1:0] row_r, row_nxt;
  logic [AW-1:0] c_in, r_in;
  logic [PW-1:0] c_ext, r_ext;
  logic          in_accept;
  logic          emit_in, last_in;

  logic          s1_v_r;
  logic          s1_adv;
  logic [AW-1:0] s1_addr_r;
  logic          s1_cell_r;
  logic          s1_emit_r;
  logic          s1_last_r;

  logic [1:0]    rd_word_r;
  logic [1:0]    fwd_word_r;
  logic          fwd_v_r;
  logic [1:0]    cur_word;
  logic [1:0]    wr_word;

  logic [8:0]    window_r, window_nxt;
  logic          rule_next;
  logic          out_v_r;
  logic          out_alive_r;
  logic          out_last_r;

  assign s1_adv    = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = clr_busy_r || (s1_v_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    c_in    = in_frame_first ? '0 : col_r;
    r_in    = in_frame_first ? '0 : row_r;
    c_ext   = PW'(c_in);
    r_ext   = PW'(r_in);
    emit_in = (r_ext >= PW'(2)) && (r_ext < side_pad)
           && (c_ext >= PW'(2)) && (c_ext < side_pad);
    last_in = (r_ext == side_pad - PW'(1)) && (c_ext == side_pad - PW'(1));
    if (c_ext + PW'(1) >= side_pad) begin
      col_nxt = '0;
      row_nxt = (r_ext + PW'(1) >= side_pad) ? '0 : r_in + AW'(1);
    end else begin
      col_nxt = c_in + AW'(1);
      row_nxt = r_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line memory: bit 1 upper row, bit 0 middle row
  logic [1:0] line_mem [DEPTH];

  assign cur_word = fwd_v_r ? fwd_word_r : rd_word_r;
  assign wr_word  = {cur_word[0], s1_cell_r};

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      line_mem[clr_addr_r] <= 2'b00;
    end else if (s1_adv) begin
      line_mem[s1_addr_r] <= wr_word;
    end
    if (in_accept) begin
      rd_word_r <= line_mem[c_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // stage 1: forward the write that shares the read's edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r  <= 1'b1;
      fwd_v_r <= s1_adv && (s1_addr_r == c_in);
    end else if (s1_adv) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r  <= c_in;
      s1_cell_r  <= in_cell_alive;
      s1_emit_r  <= emit_in;
      s1_last_r  <= last_in;
      fwd_word_r <= wr_word;
    end
  end

  // window shift and rule
  assign window_nxt = {s1_cell_r, window_r[8:7], cur_word[0], window_r[5:4],
                       cur_word[1], window_r[2:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_adv) begin
      window_r <= window_nxt;
    end
  end

  mca_rule u_rule (
    .window     (window_nxt),
    .rule_cfg   (rule_cfg_r),
    .next_alive (rule_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_alive_r <= rule_next;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_next_alive = out_alive_r;
  assign out_frame_last = out_last_r;

  // checks
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_v_r && !out_v_r))
    else $error("transaction in flight during line memory clear");

  a_first_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_frame_first) |=> (s1_addr_r == '0))
    else $error("frame start did not restart column");

  a_emit_col: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_emit_r) |-> (s1_addr_r >= AW'(2)))
    else $error("border column marked for output");

  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_v_r |-> s1_v_r)
    else $error("forward flag without stage 1 transaction");

endmodule

`default_nettype wire
